/* rtl/core/scba_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types and constants of the size class bitmap allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

	localparam int POOL_PAGES = 256;
	localparam int PAGE_W = $clog2(POOL_PAGES);
	localparam int LINK_W = PAGE_W + 1;
	localparam int SLOTS = 128;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CLASS_COUNT = 8;
	localparam int CLASS_W = $clog2(CLASS_COUNT);
	localparam int OFFSET_W = 12;
	localparam int ADDR_W = 20;
	localparam int MIN_SHIFT = 5;
	localparam logic [15:0] PAGE_BYTES = 16'd4096;

	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [LINK_W-1:0] link_t;

	localparam link_t NO_PAGE = link_t'(POOL_PAGES);

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_ZERO      = 3'd1,
		STAT_LARGE     = 3'd2,
		STAT_EXHAUSTED = 3'd3,
		STAT_FOREIGN   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_MTF1,
		S_MTF2,
		S_MTF3,
		S_NEW1,
		S_NEW2,
		S_FREE
	} state_t;

	typedef struct packed {
		page_t              rd_page;
		logic               ow_we;
		page_t              ow_wa;
		logic [CLASS_W:0]   ow_wd;
		logic               bm_we;
		page_t              bm_wa;
		logic [SLOTS-1:0]   bm_wd;
		logic               nx_we;
		page_t              nx_wa;
		link_t              nx_wd;
		logic               pv_we;
		page_t              pv_wa;
		link_t              pv_wd;
	} mem_req_t;

endpackage
`default_nettype wire

/* rtl/core/scba_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scba_mem
// Page tables: owner, slot bitmap and list links, one registered read port.
// ----------------------------------------------------------------------------
module scba_mem (
	input  wire                              clk,
	input  scba_pkg::mem_req_t               req,
	output logic [scba_pkg::CLASS_W:0]       owner_rd,
	output logic [scba_pkg::SLOTS-1:0]       bitmap_rd,
	output scba_pkg::link_t                  next_rd,
	output scba_pkg::link_t                  prev_rd
);
	import scba_pkg::*;

	logic [CLASS_W:0] owner_mem  [POOL_PAGES];
	logic [SLOTS-1:0] bitmap_mem [POOL_PAGES];
	link_t            next_mem   [POOL_PAGES];
	link_t            prev_mem   [POOL_PAGES];

	always_ff @(posedge clk) begin
		if (req.ow_we) begin
			owner_mem[req.ow_wa] <= req.ow_wd;
		end
		if (req.bm_we) begin
			bitmap_mem[req.bm_wa] <= req.bm_wd;
		end
		if (req.nx_we) begin
			next_mem[req.nx_wa] <= req.nx_wd;
		end
		if (req.pv_we) begin
			prev_mem[req.pv_wa] <= req.pv_wd;
		end
		owner_rd  <= owner_mem[req.rd_page];
		bitmap_rd <= bitmap_mem[req.rd_page];
		next_rd   <= next_mem[req.rd_page];
		prev_rd   <= prev_mem[req.rd_page];
	end

endmodule
`default_nettype wire

/* rtl/core/scba_find.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scba_find
// Lowest free slot among the slots that a page of the given class holds.
// ----------------------------------------------------------------------------
module scba_find (
	input  wire [scba_pkg::SLOTS-1:0]      bitmap,
	input  wire [scba_pkg::CLASS_W-1:0]    cls,
	output logic                           found,
	output logic [scba_pkg::SLOT_W-1:0]    slot
);
	import scba_pkg::*;

	logic [SLOTS:0]   limit;
	logic [SLOTS-1:0] free_mask;

	always_comb begin
		limit     = (SLOTS+1)'(SLOTS) >> cls;
		found     = 1'b0;
		slot      = '0;
		for (int i = 0; i < SLOTS; i++) begin
			free_mask[i] = !bitmap[i] && ((SLOTS+1)'(i) < limit);
		end
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (free_mask[i]) begin
				found = 1'b1;
				slot  = SLOT_W'(i);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/size_class_bitmap_allocator_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// size_class_bitmap_allocator_unit
// Slab allocator over a pool of 4096-byte pages split into size classes.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low: func 0
// allocates request_size bytes, func 1 releases free_address. Exactly one
// result word follows, shown on slot_address and status for one cycle
// while done is high; the receiver cannot hold it off.
// Zero-size and oversized requests, and an allocate that finds its class
// list empty with the pool used up, are answered from the idle state. A
// free reads the owner and bitmap of its page, then writes the bitmap back.
// An allocate reads one page bitmap per cycle while walking its class list;
// a hit page not yet at the head is then moved to the front of the list in
// S_MTF1 to S_MTF3, or a fresh page is taken in S_NEW1 and S_NEW2.
// The single read port of the page tables sets that rate. A new command
// may start in the cycle that shows the previous result.
// Reset empties all class lists and the pool count; page tables need no
// clearing: data read from pages at or above the pool count is never used.
// ----------------------------------------------------------------------------
module size_class_bitmap_allocator_unit (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	output logic                          busy,
	input  wire                           func,
	input  wire [15:0]                    request_size,
	input  wire [scba_pkg::ADDR_W-1:0]    free_address,
	output logic                          done,
	output logic [scba_pkg::ADDR_W-1:0]   slot_address,
	output logic [2:0]                    status
);
	import scba_pkg::*;

	state_t state_q, state_d;
	link_t  head_q [CLASS_COUNT];
	link_t  pages_used_q;
	logic   done_q;
	logic [ADDR_W-1:0] addr_q;
	status_t status_q;

	logic [CLASS_W-1:0] cls_q;
	page_t  page_q;
	logic [SLOT_W-1:0] slot_q;
	link_t  prv_q, nxt_q;
	logic [OFFSET_W-1:0] offset_q;

	mem_req_t req;
	logic [CLASS_W:0] owner_rd;
	logic [SLOTS-1:0] bitmap_rd;
	link_t next_rd, prev_rd;
	logic found;
	logic [SLOT_W-1:0] found_slot;

	logic accept, size_zero, size_large, pool_full, is_head, owned;
	logic [CLASS_W-1:0] req_cls, free_cls;
	logic [6:0] t;
	logic [SLOT_W-1:0] free_slot;
	link_t req_head, cur_head;
	logic fin;
	status_t fin_status;

	scba_mem u_mem (
		.clk(clk), .req(req), .owner_rd(owner_rd), .bitmap_rd(bitmap_rd),
		.next_rd(next_rd), .prev_rd(prev_rd)
	);

	scba_find u_find (
		.bitmap(bitmap_rd), .cls(cls_q), .found(found), .slot(found_slot)
	);

	always_comb begin
		t = 7'((request_size - 16'd1) >> MIN_SHIFT);
		req_cls = '0;
		for (int i = 0; i < 7; i++) begin
			if (t[i]) begin
				req_cls = CLASS_W'(i + 1);
			end
		end
		if (request_size <= 16'd32) begin
			req_cls = '0;
		end
	end

	assign accept     = start && !busy;
	assign size_zero  = request_size == 16'd0;
	assign size_large = request_size > PAGE_BYTES;
	assign pool_full  = pages_used_q == link_t'(POOL_PAGES);
	assign req_head   = head_q[req_cls];
	assign cur_head   = head_q[cls_q];
	assign is_head    = cur_head == link_t'(page_q);
	assign owned      = (link_t'(page_q) < pages_used_q) && (owner_rd != '0);
	assign free_cls   = CLASS_W'(owner_rd - 1'b1);
	assign free_slot  = SLOT_W'(offset_q >> (MIN_SHIFT + free_cls));
	assign busy       = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (func) begin
						state_d = S_FREE;
					end else if (!size_zero && !size_large) begin
						if (req_head != NO_PAGE) begin
							state_d = S_CHECK;
						end else if (!pool_full) begin
							state_d = S_NEW1;
						end
					end
				end
			end
			S_CHECK: begin
				if (found) begin
					state_d = is_head ? S_IDLE : S_MTF1;
				end else if (next_rd == NO_PAGE) begin
					state_d = pool_full ? S_IDLE : S_NEW1;
				end
			end
			S_MTF1:  state_d = S_MTF2;
			S_MTF2:  state_d = S_MTF3;
			S_MTF3:  state_d = S_IDLE;
			S_NEW1:  state_d = S_NEW2;
			S_NEW2:  state_d = S_IDLE;
			S_FREE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req = '0;
		req.rd_page = page_q;
		fin = 1'b0;
		fin_status = STAT_OK;
		case (state_q)
			S_IDLE: begin
				req.rd_page = func ? free_address[ADDR_W-1 -: PAGE_W] : req_head[PAGE_W-1:0];
				if (accept && !func) begin
					if (size_zero) begin
						fin = 1'b1;
						fin_status = STAT_ZERO;
					end else if (size_large) begin
						fin = 1'b1;
						fin_status = STAT_LARGE;
					end else if (req_head == NO_PAGE && pool_full) begin
						fin = 1'b1;
						fin_status = STAT_EXHAUSTED;
					end
				end
			end
			S_CHECK: begin
				req.rd_page = next_rd[PAGE_W-1:0];
				if (found) begin
					req.bm_we = 1'b1;
					req.bm_wa = page_q;
					req.bm_wd = bitmap_rd | (SLOTS'(1) << found_slot);
					fin = is_head;
				end else if (next_rd == NO_PAGE && pool_full) begin
					fin = 1'b1;
					fin_status = STAT_EXHAUSTED;
				end
			end
			S_MTF1: begin
				req.nx_we = prv_q != NO_PAGE;
				req.nx_wa = prv_q[PAGE_W-1:0];
				req.nx_wd = nxt_q;
				req.pv_we = 1'b1;
				req.pv_wa = page_q;
				req.pv_wd = NO_PAGE;
			end
			S_MTF2: begin
				req.pv_we = nxt_q != NO_PAGE;
				req.pv_wa = nxt_q[PAGE_W-1:0];
				req.pv_wd = prv_q;
				req.nx_we = 1'b1;
				req.nx_wa = page_q;
				req.nx_wd = cur_head;
			end
			S_MTF3: begin
				req.pv_we = 1'b1;
				req.pv_wa = cur_head[PAGE_W-1:0];
				req.pv_wd = link_t'(page_q);
				fin = 1'b1;
			end
			S_NEW1: begin
				req.ow_we = 1'b1;
				req.ow_wa = pages_used_q[PAGE_W-1:0];
				req.ow_wd = (CLASS_W+1)'(cls_q) + 1'b1;
				req.bm_we = 1'b1;
				req.bm_wa = pages_used_q[PAGE_W-1:0];
				req.bm_wd = SLOTS'(1);
				req.nx_we = 1'b1;
				req.nx_wa = pages_used_q[PAGE_W-1:0];
				req.nx_wd = cur_head;
				req.pv_we = 1'b1;
				req.pv_wa = pages_used_q[PAGE_W-1:0];
				req.pv_wd = NO_PAGE;
			end
			S_NEW2: begin
				req.pv_we = cur_head != NO_PAGE;
				req.pv_wa = cur_head[PAGE_W-1:0];
				req.pv_wd = link_t'(page_q);
				fin = 1'b1;
			end
			S_FREE: begin
				fin = 1'b1;
				if (owned) begin
					req.bm_we = 1'b1;
					req.bm_wa = page_q;
					req.bm_wd = bitmap_rd & ~(SLOTS'(1) << free_slot);
				end else begin
					fin_status = STAT_FOREIGN;
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pages_used_q <= '0;
			done_q       <= 1'b0;
			for (int c = 0; c < CLASS_COUNT; c++) begin
				head_q[c] <= NO_PAGE;
			end
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == S_NEW1) begin
				pages_used_q <= pages_used_q + 1'b1;
			end
			if (state_q == S_MTF3 || state_q == S_NEW2) begin
				head_q[cls_q] <= link_t'(page_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			cls_q    <= req_cls;
			page_q   <= req.rd_page;
			offset_q <= free_address[OFFSET_W-1:0];
		end
		if (state_q == S_CHECK) begin
			if (found) begin
				slot_q <= found_slot;
				prv_q  <= prev_rd;
				nxt_q  <= next_rd;
			end else begin
				page_q <= next_rd[PAGE_W-1:0];
			end
		end
		if (state_q == S_NEW1) begin
			page_q <= pages_used_q[PAGE_W-1:0];
			slot_q <= '0;
		end
		if (fin) begin
			status_q <= fin_status;
			if (fin_status == STAT_OK && state_q != S_FREE) begin
				addr_q <= {(state_q == S_CHECK) ? page_q : page_q,
					OFFSET_W'({5'd0, (state_q == S_CHECK) ? found_slot : slot_q}
						<< (MIN_SHIFT + cls_q))};
			end else begin
				addr_q <= '0;
			end
		end
	end

	assign done         = done_q;
	assign slot_address = addr_q;
	assign status       = status_q;

endmodule
`default_nettype wire

/* rtl/core/scba_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scba_port_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module scba_port_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           start,
	input wire                           busy,
	input wire                           done,
	input wire [scba_pkg::ADDR_W-1:0]    slot_address,
	input wire [2:0]                     status
);
	import scba_pkg::*;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != STAT_OK |-> slot_address == '0)
		else $error("failed result carries an address");

	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done) else $error("command lost");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= 3'd4) else $error("status code out of range");

endmodule

bind size_class_bitmap_allocator_unit scba_port_checker u_scba_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.slot_address(slot_address), .status(status)
);
`default_nettype wire
